// ----- hdl/htcfp_pkg.sv -----
// Shared types and constants for the header/tail checksum frame parser.
// Used by every module of the block; depends on nothing.
`default_nettype none

package htcfp_pkg;

  localparam int BYTE_W = 8;
  localparam int CFG_INDEX_W = 2;
  localparam logic [BYTE_W-1:0] BASE_LENGTH = 8'd8;

  localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h55;
  localparam logic [BYTE_W-1:0] TAIL_RESET = 8'hbb;
  localparam logic [BYTE_W-1:0] MARKER_RESET = 8'hfd;

  localparam logic [CFG_INDEX_W-1:0] REG_HEADER = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TAIL = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MARKER = 2'd2;

  typedef enum logic [3:0] {
    ST_DROPPED   = 4'd0,
    ST_RECEIVING = 4'd1,
    ST_SUM_OK    = 4'd2,
    ST_SUM_BAD   = 4'd3,
    ST_LONG_DONE = 4'd4,
    ST_SHORT_OK  = 4'd5,
    ST_SHORT_BAD = 4'd6,
    ST_ERROR     = 4'd7,
    ST_LEN_TAKEN = 4'd8
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] header_byte;
    logic [BYTE_W-1:0] tail_byte;
    logic [BYTE_W-1:0] extended_marker;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_echo;
    logic [BYTE_W-1:0] byte_position;
    logic              in_frame;
    status_t           frame_status;
    logic              frame_end;
    logic              checksum_good_flag;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/htcfp_cfg_regs.sv -----
// Configuration register file: header, tail and extended marker values.
// Depends on htcfp_pkg.
`default_nettype none

module htcfp_cfg_regs import htcfp_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]      cfg_data,
  output cfg_t                        cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_byte <= HEADER_RESET;
      cfg.tail_byte <= TAIL_RESET;
      cfg.extended_marker <= MARKER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HEADER: cfg.header_byte <= cfg_data;
        REG_TAIL: cfg.tail_byte <= cfg_data;
        REG_MARKER: cfg.extended_marker <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/htcfp_in_stage.sv -----
// Input register stage that holds one received word ahead of the parser.
// Depends on htcfp_pkg.
`default_nettype none

module htcfp_in_stage import htcfp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [BYTE_W-1:0] s_tdata,
  output logic                   in_valid,
  output logic [BYTE_W-1:0]      in_byte,
  input  wire logic              take
);

  assign s_tready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (take) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/htcfp_parser.sv -----
// Frame state, per-word judgement logic and the result register.
// Depends on htcfp_pkg.
`default_nettype none

module htcfp_parser import htcfp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cfg_t              cfg,
  input  wire logic              in_valid,
  input  wire logic [BYTE_W-1:0] in_byte,
  output logic                   take,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output result_t                result
);

  logic [BYTE_W-1:0] byte_count, byte_count_next;
  logic [BYTE_W-1:0] frame_length, frame_length_next;
  logic              extended_mode, extended_mode_next;
  logic [BYTE_W-1:0] type_byte, type_byte_next;
  logic [BYTE_W-1:0] length_byte, length_byte_next;
  logic [BYTE_W-1:0] running_sum, running_sum_next;
  logic [BYTE_W-1:0] check_byte, check_byte_next;
  logic              sum_ok_flag, sum_ok_flag_next;
  result_t           result_next;

  logic [BYTE_W-1:0] pos;
  logic              stored;
  logic              tail_ok;
  logic              ext_type;
  status_t           status;

  assign take = in_valid && (!out_valid || out_ready);

  always_comb begin
    byte_count_next = byte_count;
    frame_length_next = frame_length;
    extended_mode_next = extended_mode;
    type_byte_next = type_byte;
    length_byte_next = length_byte;
    running_sum_next = running_sum;
    check_byte_next = check_byte;
    sum_ok_flag_next = sum_ok_flag;
    pos = '0;
    stored = 1'b0;
    status = ST_DROPPED;
    tail_ok = (in_byte == cfg.tail_byte);
    ext_type = 1'b0;

    if (byte_count != '0) begin
      pos = byte_count;
      byte_count_next = byte_count + 1'b1;
      stored = 1'b1;
    end else if (in_byte == cfg.header_byte) begin
      byte_count_next = 8'd1;
      running_sum_next = '0;
      stored = 1'b1;
    end

    if (stored) begin
      if (pos == 8'd1) type_byte_next = in_byte;
      if (pos == 8'd2) length_byte_next = in_byte;
      if (pos >= 8'd2 && pos <= 8'd5) running_sum_next = running_sum_next + in_byte;
      if (pos == 8'd6) check_byte_next = in_byte;
      status = ST_RECEIVING;
      ext_type = (type_byte_next == cfg.extended_marker);

      if (byte_count_next >= frame_length) begin
        priority if (tail_ok && !extended_mode && !ext_type) begin
          byte_count_next = '0;
          if (running_sum_next == check_byte_next) begin
            sum_ok_flag_next = 1'b1;
            status = ST_SUM_OK;
          end else begin
            sum_ok_flag_next = 1'b0;
            status = ST_SUM_BAD;
          end
        end else if (ext_type && !extended_mode) begin
          if (length_byte_next > BASE_LENGTH) begin
            frame_length_next = length_byte_next;
            extended_mode_next = 1'b1;
            status = ST_LEN_TAKEN;
          end else begin
            byte_count_next = '0;
            if (tail_ok) begin
              extended_mode_next = 1'b0;
              frame_length_next = BASE_LENGTH;
              status = ST_SHORT_OK;
            end else begin
              status = ST_SHORT_BAD;
            end
          end
        end else if (extended_mode && tail_ok) begin
          byte_count_next = '0;
          extended_mode_next = 1'b0;
          frame_length_next = BASE_LENGTH;
          status = ST_LONG_DONE;
        end else begin
          sum_ok_flag_next = 1'b0;
          byte_count_next = '0;
          extended_mode_next = 1'b0;
          frame_length_next = BASE_LENGTH;
          status = ST_ERROR;
        end
      end
    end

    result_next.byte_echo = in_byte;
    result_next.byte_position = pos;
    result_next.in_frame = stored;
    result_next.frame_status = status;
    result_next.frame_end = (status != ST_DROPPED) && (status != ST_RECEIVING)
                            && (status != ST_LEN_TAKEN);
    result_next.checksum_good_flag = sum_ok_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      frame_length <= BASE_LENGTH;
      extended_mode <= 1'b0;
      type_byte <= '0;
      length_byte <= '0;
      running_sum <= '0;
      check_byte <= '0;
      sum_ok_flag <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        byte_count <= byte_count_next;
        frame_length <= frame_length_next;
        extended_mode <= extended_mode_next;
        type_byte <= type_byte_next;
        length_byte <= length_byte_next;
        running_sum <= running_sum_next;
        check_byte <= check_byte_next;
        sum_ok_flag <= sum_ok_flag_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/header_tail_checksum_frame_parser.sv -----
// Top level of the header/tail checksum frame parser.
// Depends on htcfp_pkg, htcfp_cfg_regs, htcfp_in_stage and htcfp_parser.
//
// The block takes one received byte per word and returns one result word for
// each, one word per clock cycle sustained while m_tready is high. The input
// register and the result register each hold one word, so a new byte is
// taken while a result waits downstream. The frame state is updated by a
// combinational compare-and-add step in the parser, which sets the
// one-word-per-cycle rate. Configuration is written through the cfg channel,
// which is always ready; write only while the block is idle.
`default_nettype none

module header_tail_checksum_frame_parser import htcfp_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // Fields from bit 0: rx_byte[7:0].
  input  wire logic [7:0]             s_tdata,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // Fields from bit 0: byte_echo[7:0], byte_position[15:8], in_frame[16],
  // checksum_good_flag[17], zero fill[23:18].
  output logic [23:0]                 m_tdata,
  // Fields from bit 0: frame_status[3:0].
  output logic [3:0]                  m_tuser,
  output logic                        m_tlast,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]      cfg_data
);

  cfg_t              cfg;
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              take;
  result_t           result;

  htcfp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  htcfp_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .take     (take)
  );

  htcfp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_byte   (in_byte),
    .take      (take),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .result    (result)
  );

  assign m_tdata = {6'b0, result.checksum_good_flag, result.in_frame,
                    result.byte_position, result.byte_echo};
  assign m_tuser = result.frame_status;
  assign m_tlast = result.frame_end;

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the header/tail checksum frame parser.
// Depends on htcfp_pkg and header_tail_checksum_frame_parser.

module tb;
  import htcfp_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int PHASE_BYTES = 170;

  typedef enum {
    FK_SUM_OK,
    FK_SUM_BAD,
    FK_PLAIN_BAD_TAIL,
    FK_SHORT_OK,
    FK_SHORT_BAD_TAIL,
    FK_LONG_OK,
    FK_LONG_BAD_TAIL,
    FK_BROKEN
  } frame_kind_t;

  class parser_scoreboard;
    logic [7:0] header_reg;
    logic [7:0] tail_reg;
    logic [7:0] marker_reg;
    logic [7:0] count;
    logic [7:0] frame_len;
    bit         ext_mode;
    logic [7:0] type_b;
    logic [7:0] len_b;
    logic [7:0] sum;
    logic [7:0] check_b;
    bit         sum_good;
    result_t    expected_results[$];
    int         errors;

    function new();
      header_reg = HEADER_RESET;
      tail_reg = TAIL_RESET;
      marker_reg = MARKER_RESET;
      count = '0;
      frame_len = BASE_LENGTH;
      ext_mode = 1'b0;
      type_b = '0;
      len_b = '0;
      sum = '0;
      check_b = '0;
      sum_good = 1'b0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [7:0] v);
      case (idx)
        REG_HEADER: header_reg = v;
        REG_TAIL:   tail_reg = v;
        REG_MARKER: marker_reg = v;
        default: ;
      endcase
    endfunction

    function bit frame_open();
      return count != 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void restart();
      count = '0;
      ext_mode = 1'b0;
      frame_len = BASE_LENGTH;
    endfunction

    // Advance the frame state by one accepted byte and queue its result.
    function void predict_byte(logic [7:0] b);
      logic [7:0] pos;
      bit         stored;
      bit         tail_ok;
      bit         ext_type;
      status_t    st;
      result_t    r;
      pos = '0;
      stored = 1'b0;
      st = ST_DROPPED;
      if (count != 0) begin
        pos = count;
        count = count + 8'd1;
        stored = 1'b1;
      end else if (b == header_reg) begin
        count = 8'd1;
        sum = '0;
        stored = 1'b1;
      end
      if (stored) begin
        if (pos == 8'd1) type_b = b;
        if (pos == 8'd2) len_b = b;
        if (pos >= 8'd2 && pos <= 8'd5) sum = sum + b;
        if (pos == 8'd6) check_b = b;
        st = ST_RECEIVING;
        if (count >= frame_len) begin
          tail_ok = (b == tail_reg);
          ext_type = (type_b == marker_reg);
          if (tail_ok && !ext_mode && !ext_type) begin
            count = '0;
            sum_good = (sum == check_b);
            st = sum_good ? ST_SUM_OK : ST_SUM_BAD;
          end else if (ext_type && !ext_mode) begin
            if (len_b > BASE_LENGTH) begin
              frame_len = len_b;
              ext_mode = 1'b1;
              st = ST_LEN_TAKEN;
            end else begin
              count = '0;
              if (tail_ok) begin
                restart();
                st = ST_SHORT_OK;
              end else begin
                st = ST_SHORT_BAD;
              end
            end
          end else if (ext_mode && tail_ok) begin
            restart();
            st = ST_LONG_DONE;
          end else begin
            sum_good = 1'b0;
            restart();
            st = ST_ERROR;
          end
        end
      end
      r.byte_echo = b;
      r.byte_position = pos;
      r.in_frame = stored;
      r.frame_status = st;
      r.frame_end = (st >= ST_SUM_OK && st <= ST_ERROR);
      r.checksum_good_flag = sum_good;
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(logic [23:0] data, logic [3:0] user, logic last);
      result_t e;
      if (expected_results.size() == 0) begin
        $display("%0t: result word with nothing expected, actual %h/%h/%b",
                 $time, data, user, last);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      compare_field("byte_echo", e.byte_echo, data[7:0]);
      compare_field("byte_position", e.byte_position, data[15:8]);
      compare_field("in_frame", e.in_frame, data[16]);
      compare_field("checksum_good_flag", e.checksum_good_flag, data[17]);
      compare_field("frame_status", e.frame_status, user);
      compare_field("frame_end", e.frame_end, last);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [7:0]             s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [23:0]            m_tdata;
  logic [3:0]             m_tuser;
  logic                   m_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0]      cfg_data = '0;

  parser_scoreboard sb = new();
  int tx_max = 12;
  int rx_max = 12;
  int n_sent = 0;
  int idle_cycles = 0;

  header_tail_checksum_frame_parser i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL header_tail_checksum_frame_parser");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = $urandom_range(0, rx_max);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_result(m_tdata, m_tuser, m_tlast);
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, tx_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    sb.predict_byte(b);
    n_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic send_noise();
    logic [7:0] b;
    repeat ($urandom_range(1, 3)) begin
      b = 8'($urandom);
      if (b == sb.header_reg && $urandom_range(0, 3) != 0) b ^= 8'h80;
      send_byte(b);
    end
  endtask

  task automatic send_frame(input frame_kind_t kind);
    logic [7:0] fr[$];
    logic [7:0] t;
    logic [7:0] s;
    int len;
    while (sb.frame_open()) send_byte(8'($urandom));
    fr.push_back(sb.header_reg);
    case (kind)
      FK_SUM_OK, FK_SUM_BAD, FK_PLAIN_BAD_TAIL: begin
        t = 8'($urandom);
        if (t == sb.marker_reg) t ^= 8'h01;
        fr.push_back(t);
        s = '0;
        repeat (4) begin
          t = 8'($urandom);
          s += t;
          fr.push_back(t);
        end
        fr.push_back(kind == FK_SUM_BAD ? s + 8'($urandom_range(1, 255)) : s);
        fr.push_back(kind == FK_PLAIN_BAD_TAIL ?
                     sb.tail_reg ^ 8'($urandom_range(1, 255)) : sb.tail_reg);
      end
      FK_SHORT_OK, FK_SHORT_BAD_TAIL: begin
        fr.push_back(sb.marker_reg);
        fr.push_back(8'($urandom_range(0, 8)));
        repeat (4) fr.push_back(8'($urandom));
        fr.push_back(kind == FK_SHORT_BAD_TAIL ?
                     sb.tail_reg ^ 8'($urandom_range(1, 255)) : sb.tail_reg);
      end
      FK_LONG_OK, FK_LONG_BAD_TAIL: begin
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 255) : $urandom_range(9, 16);
        fr.push_back(sb.marker_reg);
        fr.push_back(8'(len));
        repeat (len - 4) fr.push_back(8'($urandom));
        fr.push_back(kind == FK_LONG_BAD_TAIL ?
                     sb.tail_reg ^ 8'($urandom_range(1, 255)) : sb.tail_reg);
      end
      default: begin
        repeat ($urandom_range(0, 6)) fr.push_back(8'($urandom));
      end
    endcase
    foreach (fr[i]) send_byte(fr[i]);
  endtask

  initial begin
    logic [7:0] directed[$];
    int phase_start;
    bit paused;
    // Dropped bytes, a good plain frame, a short extended frame with a bad
    // tail and the shortest frame that carries its own length.
    directed = '{8'h00, 8'hff,
                 8'h55, 8'h00, 8'hff, 8'h01, 8'h02, 8'h03, 8'h05, 8'hbb,
                 8'h55, 8'hfd, 8'h08, 8'h55, 8'h00, 8'hff, 8'h10, 8'h00,
                 8'h55, 8'hfd, 8'h09, 8'hff, 8'h00, 8'h55, 8'h12, 8'h34, 8'hbb};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      repeat (4) @(posedge clk);
      case (ph)
        0: ;
        1: begin
          write_reg(REG_HEADER, 8'h00);
          write_reg(REG_TAIL, 8'h00);
          write_reg(REG_MARKER, 8'h00);
        end
        2: begin
          write_reg(REG_HEADER, 8'hff);
          write_reg(REG_TAIL, 8'hff);
          write_reg(REG_MARKER, 8'hff);
        end
        default: begin
          write_reg(REG_HEADER, 8'($urandom));
          write_reg(REG_TAIL, 8'($urandom));
          write_reg(REG_MARKER, 8'($urandom));
        end
      endcase
      if (ph == 0) begin
        foreach (directed[i]) send_byte(directed[i]);
      end
      phase_start = n_sent;
      paused = 1'b0;
      while (n_sent - phase_start < PHASE_BYTES) begin
        if ($urandom_range(0, 7) == 0) begin
          tx_max = $urandom_range(0, 1) ? 12 : 0;
          rx_max = $urandom_range(0, 1) ? 12 : 0;
        end
        if (!paused && n_sent - phase_start >= PHASE_BYTES / 2) begin
          drain();
          paused = 1'b1;
        end
        if ($urandom_range(0, 5) == 0) begin
          send_noise();
        end else begin
          send_frame(frame_kind_t'($urandom_range(0, 7)));
        end
      end
    end
    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS header_tail_checksum_frame_parser");
    end else begin
      $display("FAIL header_tail_checksum_frame_parser");
    end
    $finish;
  end

endmodule
